>>> hw/rtl/stimulus_pulse_train_sequencer_core_macros.svh
// ----------------------------------------------------------------------------
// Stimulus pulse train sequencer assertion macros
// Concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef STIMULUS_PULSE_TRAIN_SEQUENCER_CORE_MACROS_SVH
`define STIMULUS_PULSE_TRAIN_SEQUENCER_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define SPTS_ASSERT_CLK(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SPTS_ASSERT(name, prop, msg) \
  `SPTS_ASSERT_CLK(name, clk_i, rst_ni, prop, msg)
`else
`define SPTS_ASSERT_CLK(name, clk, rst_n, prop, msg)
`define SPTS_ASSERT(name, prop, msg)
`endif

`endif

>>> hw/rtl/spts_pkg.sv
// ----------------------------------------------------------------------------
// Stimulus pulse train sequencer package
// Payload types, operation and edge codes, register indexes and reset values.
// ----------------------------------------------------------------------------
package spts_pkg;

  localparam int unsigned OP_W    = 2;
  localparam int unsigned SAMPLE_W = 32;
  localparam int unsigned RND_W   = 31;
  localparam int unsigned REG_W   = 16;
  localparam int unsigned TICKS_W = 17;
  localparam int unsigned IDX_W   = 2;
  localparam int unsigned DIV_CNT_W = $clog2(RND_W);

  typedef enum logic [OP_W-1:0] {
    OP_TICK  = 2'd0,
    OP_START = 2'd1,
    OP_STOP  = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    EDGE_NONE  = 2'd0,
    EDGE_START = 2'd1,
    EDGE_END   = 2'd2
  } edge_e;

  typedef enum logic [IDX_W-1:0] {
    CFG_TRIAL_TOTAL = 2'd0,
    CFG_PULSE_TICKS = 2'd1,
    CFG_GAP_BASE    = 2'd2,
    CFG_GAP_JITTER  = 2'd3
  } cfg_idx_e;

  localparam logic [REG_W-1:0] TRIAL_TOTAL_RST = 16'd0;
  localparam logic [REG_W-1:0] PULSE_TICKS_RST = 16'd100;
  localparam logic [REG_W-1:0] GAP_BASE_RST    = 16'd1000;
  localparam logic [REG_W-1:0] GAP_JITTER_RST  = 16'd0;

  typedef struct packed {
    logic [OP_W-1:0]     operation;
    logic [SAMPLE_W-1:0] sample_count;
    logic [RND_W-1:0]    random_word;
  } spts_in_t;

  typedef struct packed {
    logic                pulse_active;
    logic [1:0]          edge_event;
    logic [SAMPLE_W-1:0] edge_sample;
    logic                running;
    logic [REG_W-1:0]    trials_done;
  } spts_out_t;

  typedef struct packed {
    logic load;
    logic div_start;
    logic commit;
  } spts_cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_done;
    logic out_free;
  } spts_sts_t;

endpackage

>>> hw/rtl/spts_mod.sv
// ----------------------------------------------------------------------------
// Stimulus pulse train sequencer remainder unit
// Restoring bit-serial remainder of the random word by the jitter bound.
// ----------------------------------------------------------------------------
module spts_mod (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [spts_pkg::RND_W-1:0]     dividend_i,
  input  logic [spts_pkg::REG_W-1:0]     divisor_i,
  output logic                           done_o,
  output logic [spts_pkg::REG_W-1:0]     rem_o
);
  import spts_pkg::*;

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [RND_W-1:0]     num_q, num_d;
  logic [REG_W-1:0]     rem_q, rem_d;
  logic [REG_W:0]       trial;

  always_comb begin
    trial  = {rem_q, num_q[RND_W-1]};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    num_d  = num_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = DIV_CNT_W'(RND_W - 1);
      num_d  = dividend_i;
      rem_d  = '0;
    end else if (busy_q) begin
      num_d = {num_q[RND_W-2:0], 1'b0};
      if (trial >= {1'b0, divisor_i}) begin
        rem_d = REG_W'(trial - {1'b0, divisor_i});
      end else begin
        rem_d = trial[REG_W-1:0];
      end
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

>>> hw/rtl/spts_datapath.sv
// ----------------------------------------------------------------------------
// Stimulus pulse train sequencer datapath
// Configuration, train state, item register, gap draw and result register.
// ----------------------------------------------------------------------------
`include "stimulus_pulse_train_sequencer_core_macros.svh"

module spts_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [spts_pkg::IDX_W-1:0]    cfg_idx_i,
  input  logic [spts_pkg::REG_W-1:0]    cfg_wdata_i,
  input  spts_pkg::spts_in_t            in_data_i,
  input  spts_pkg::spts_cmd_t           cmd_i,
  output spts_pkg::spts_sts_t           sts_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output spts_pkg::spts_out_t           out_data_o
);
  import spts_pkg::*;

  logic [REG_W-1:0]   trial_total_q, pulse_ticks_q, gap_base_q, gap_jitter_q;
  logic               active_q, active_d;
  logic               in_pulse_q, in_pulse_d;
  logic [TICKS_W-1:0] ticks_q, ticks_d;
  logic [REG_W-1:0]   count_q, count_d;
  spts_in_t           item_q;
  spts_out_t          out_q, out_d;
  logic               out_valid_q, out_valid_d;
  edge_e              edge_d;
  logic [REG_W-1:0]   count_inc;
  logic [REG_W-1:0]   extra;
  logic [REG_W-1:0]   rem;
  logic               div_done;
  logic               gap_case;

  spts_mod u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (item_q.random_word),
    .divisor_i  (gap_jitter_q),
    .done_o     (div_done),
    .rem_o      (rem)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trial_total_q <= TRIAL_TOTAL_RST;
      pulse_ticks_q <= PULSE_TICKS_RST;
      gap_base_q    <= GAP_BASE_RST;
      gap_jitter_q  <= GAP_JITTER_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_TRIAL_TOTAL: trial_total_q <= cfg_wdata_i;
        CFG_PULSE_TICKS: pulse_ticks_q <= cfg_wdata_i;
        CFG_GAP_BASE:    gap_base_q    <= cfg_wdata_i;
        CFG_GAP_JITTER:  gap_jitter_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign count_inc = (count_q != '1) ? count_q + 1'b1 : count_q;
  assign gap_case  = (op_e'(item_q.operation) == OP_TICK) && active_q &&
                     (ticks_q <= TICKS_W'(1)) && in_pulse_q &&
                     (count_inc < trial_total_q);
  assign extra     = (gap_jitter_q != '0) ? rem : '0;

  always_comb begin
    active_d   = active_q;
    in_pulse_d = in_pulse_q;
    ticks_d    = ticks_q;
    count_d    = count_q;
    edge_d     = EDGE_NONE;
    case (op_e'(item_q.operation))
      OP_START: begin
        if (!active_q) begin
          active_d   = 1'b1;
          count_d    = '0;
          in_pulse_d = 1'b1;
          ticks_d    = {1'b0, pulse_ticks_q};
          edge_d     = EDGE_START;
        end
      end
      OP_STOP: begin
        if (active_q) begin
          active_d   = 1'b0;
          in_pulse_d = 1'b0;
          ticks_d    = '0;
        end
      end
      OP_TICK: begin
        if (active_q) begin
          if (ticks_q > TICKS_W'(1)) begin
            ticks_d = ticks_q - 1'b1;
          end else if (in_pulse_q) begin
            in_pulse_d = 1'b0;
            edge_d     = EDGE_END;
            count_d    = count_inc;
            if (count_inc >= trial_total_q) begin
              active_d = 1'b0;
              ticks_d  = '0;
            end else begin
              ticks_d = {1'b0, gap_base_q} + {1'b0, extra};
            end
          end else begin
            in_pulse_d = 1'b1;
            ticks_d    = {1'b0, pulse_ticks_q};
            edge_d     = EDGE_START;
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    out_d.pulse_active = in_pulse_d;
    out_d.edge_event   = edge_d;
    out_d.edge_sample  = (edge_d != EDGE_NONE) ? item_q.sample_count : '0;
    out_d.running      = active_d;
    out_d.trials_done  = count_d;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      in_pulse_q  <= 1'b0;
      ticks_q     <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (cmd_i.commit) begin
        active_q   <= active_d;
        in_pulse_q <= in_pulse_d;
        ticks_q    <= ticks_d;
        count_q    <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= in_data_i;
    end
    if (cmd_i.commit) begin
      out_q <= out_d;
    end
  end

  assign sts_o.need_div = gap_case && (gap_jitter_q != '0);
  assign sts_o.div_done = div_done;
  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign out_data_o     = out_q;

  `SPTS_ASSERT(a_idle_no_pulse, !active_q |-> !in_pulse_q, "pulse open while idle")
  `SPTS_ASSERT(a_no_edge_zero, out_valid_q && (out_q.edge_event == EDGE_NONE) |-> out_q.edge_sample == '0, "edge sample set without edge")
  `SPTS_ASSERT(a_stop_closes, out_valid_q && !out_q.running |-> !out_q.pulse_active, "pulse reported after train end")
  `SPTS_ASSERT(a_rem_bound, div_done && (gap_jitter_q != '0) |=> rem < gap_jitter_q, "remainder not below bound")

endmodule

>>> hw/rtl/spts_ctrl.sv
// ----------------------------------------------------------------------------
// Stimulus pulse train sequencer controller
// Sequences item capture, optional gap draw and state commit.
// ----------------------------------------------------------------------------
module spts_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  spts_pkg::spts_sts_t  sts_i,
  output spts_pkg::spts_cmd_t  cmd_o
);
  import spts_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_DIV,
    S_COMMIT
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d          = state_q;
    cmd_o.load       = 1'b0;
    cmd_o.div_start  = 1'b0;
    cmd_o.commit     = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EVAL;
        end
      end
      S_EVAL: begin
        if (sts_i.need_div) begin
          cmd_o.div_start = 1'b1;
          state_d         = S_DIV;
        end else begin
          state_d = S_COMMIT;
        end
      end
      S_DIV: begin
        if (sts_i.div_done) begin
          state_d = S_COMMIT;
        end
      end
      S_COMMIT: begin
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

endmodule

>>> hw/rtl/stimulus_pulse_train_sequencer_core.sv
// ----------------------------------------------------------------------------
// Stimulus pulse train sequencer core
// Runs pulse trains from tick, start and stop transactions.
// ----------------------------------------------------------------------------
// A transaction is captured, evaluated and committed in turn; a tick that
// ends a pulse and draws a jittered gap also waits on the 31-step bit-serial
// remainder unit. The result waits in an output register, so the
// next transaction is taken as soon as the previous one commits.
module stimulus_pulse_train_sequencer_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  spts_pkg::spts_in_t          in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output spts_pkg::spts_out_t         out_data_o,
  input  logic                        cfg_we_i,
  input  logic [spts_pkg::IDX_W-1:0]  cfg_idx_i,
  input  logic [spts_pkg::REG_W-1:0]  cfg_wdata_i
);
  import spts_pkg::*;

  spts_cmd_t cmd;
  spts_sts_t sts;

  spts_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  spts_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
